// ===== src/polygon_normal_triangulator_assert.svh =====
// assertion helpers used by the block's controller
`ifndef POLYGON_NORMAL_TRIANGULATOR_ASSERT_SVH
`define POLYGON_NORMAL_TRIANGULATOR_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define PNT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define PNT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== src/pnt_pkg.sv =====
`timescale 1ns / 1ps

package pnt_pkg;

    localparam int MAX_VERTS_DEF  = 16;
    localparam int COORD_BITS_DEF = 24;
    localparam int POS_W          = 24;
    localparam int NRM_W          = 16;
    localparam int FACE_W         = 16;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_FEW  = 2'd1;
    localparam status_t ST_MANY = 2'd2;

    typedef struct packed {
        logic [FACE_W-1:0]        face_id;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic                     last_vertex;
    } vert_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  out_x;
        logic signed [POS_W-1:0]  out_y;
        logic signed [POS_W-1:0]  out_z;
        logic signed [NRM_W-1:0]  norm_x;
        logic signed [NRM_W-1:0]  norm_y;
        logic signed [NRM_W-1:0]  norm_z;
        logic [FACE_W-1:0]        out_face_id;
        status_t                  status;
        logic                     last_of_run;
    } res_item_t;

    // products taken by the shared multiplier, a and b are the edge vectors (the diagonals for a quad)
    typedef enum logic [3:0] {
        MS_AYBZ = 4'd0,
        MS_AZBY = 4'd1,
        MS_AZBX = 4'd2,
        MS_AXBZ = 4'd3,
        MS_AXBY = 4'd4,
        MS_AYBX = 4'd5,
        MS_AXAX = 4'd6,
        MS_AYAY = 4'd7,
        MS_AZAZ = 4'd8,
        MS_BXBX = 4'd9,
        MS_BYBY = 4'd10,
        MS_BZBZ = 4'd11
    } mul_sel_t;

    typedef struct packed {
        logic     wr_en;
        logic     face_latch;
        logic     rd_en;
        logic [1:0] rd_slot;
        logic     diff_en;
        logic     acc_clr;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     norm_init;
        logic     shift_en;
        logic     sq_en;
        logic     sum_en;
        logic     srch_a;
        logic     srch_b;
        logic [1:0] comp;
        logic [3:0] bitpos;
        logic     out_load;
        logic     out_err;
        status_t  err_code;
        logic     out_last;
    } pnt_cmd_t;

    typedef struct packed {
        logic big;
        logic quad_rot;
        logic out_free;
    } pnt_sts_t;

endpackage

// ===== src/pnt_ctrl.sv =====
`timescale 1ns / 1ps
`include "polygon_normal_triangulator_assert.svh"

module pnt_ctrl #(
    parameter int MAX_VERTS = pnt_pkg::MAX_VERTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          vert_valid,
    input  logic                          vert_last,
    output logic                          vert_stall,
    input  pnt_pkg::pnt_sts_t             sts,
    output pnt_pkg::pnt_cmd_t             cmd,
    output logic [$clog2(MAX_VERTS)-1:0]  wr_addr,
    output logic [$clog2(MAX_VERTS)-1:0]  rd_addr
);

    localparam int IDX_W = $clog2(MAX_VERTS);
    localparam int CNT_W = $clog2(MAX_VERTS + 1);

    typedef enum logic [13:0] {
        S_LOAD  = 14'b00000000000001,
        S_RD    = 14'b00000000000010,
        S_DIFF  = 14'b00000000000100,
        S_MUL   = 14'b00000000001000,
        S_MWAIT = 14'b00000000010000,
        S_INIT  = 14'b00000000100000,
        S_SHIFT = 14'b00000001000000,
        S_SQ    = 14'b00000010000000,
        S_SUM   = 14'b00000100000000,
        S_SA    = 14'b00001000000000,
        S_SB    = 14'b00010000000000,
        S_EMRD  = 14'b00100000000000,
        S_EMWR  = 14'b01000000000000,
        S_ERR   = 14'b10000000000000
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  ovf_reg, ovf_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [IDX_W-1:0]      term_reg, term_next;
    logic [1:0]            rcnt_reg, rcnt_next;
    logic [3:0]            mcnt_reg, mcnt_next;
    logic [1:0]            comp_reg, comp_next;
    logic [3:0]            bit_reg, bit_next;
    logic [IDX_W-1:0]      tri_reg, tri_next;
    logic [1:0]            corner_reg, corner_next;
    logic                  rot_reg, rot_next;
    pnt_pkg::status_t      errc_reg, errc_next;

    logic                  accept;
    logic [CNT_W-1:0]      n_new;
    logic                  ovf_new;
    logic [IDX_W-1:0]      i1, i2, ebase, eidx;
    logic                  emit_last;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x,
                                                  input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] t;
        t = CNT_W'(x) + CNT_W'(1);
        return (t == n) ? '0 : t[IDX_W-1:0];
    endfunction

    assign vert_stall = (state_reg != S_LOAD);
    assign accept     = vert_valid && (state_reg == S_LOAD);
    assign wr_addr    = cnt_reg[IDX_W-1:0];
    assign ovf_new    = ovf_reg || (cnt_reg == CNT_W'(MAX_VERTS));
    assign n_new      = (cnt_reg < CNT_W'(MAX_VERTS)) ? cnt_reg + CNT_W'(1) : cnt_reg;

    assign i1 = wrap_inc(term_reg, n_reg);
    assign i2 = wrap_inc(i1, n_reg);

    // fan corner, rotated by one vertex for a quad split on the other diagonal
    always_comb
    begin
        unique case (corner_reg)
            2'd1:    ebase = tri_reg + IDX_W'(1);
            2'd2:    ebase = tri_reg + IDX_W'(2);
            default: ebase = '0;
        endcase
        eidx = rot_reg ? wrap_inc(ebase, n_reg) : ebase;
    end

    assign emit_last = (corner_reg == 2'd2) && (CNT_W'(tri_reg) + CNT_W'(3) == n_reg);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        n_next      = n_reg;
        term_next   = term_reg;
        rcnt_next   = rcnt_reg;
        mcnt_next   = mcnt_reg;
        comp_next   = comp_reg;
        bit_next    = bit_reg;
        tri_next    = tri_reg;
        corner_next = corner_reg;
        rot_next    = rot_reg;
        errc_next   = errc_reg;
        rd_addr     = '0;

        cmd            = '0;
        cmd.mul_sel    = pnt_pkg::mul_sel_t'(mcnt_reg);
        cmd.comp       = comp_reg;
        cmd.bitpos     = bit_reg;
        cmd.err_code   = errc_reg;
        cmd.rd_slot    = rcnt_reg;
        cmd.out_last   = emit_last;

        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    cmd.wr_en      = (cnt_reg < CNT_W'(MAX_VERTS));
                    cmd.face_latch = (cnt_reg == '0) && !ovf_reg;
                    if (vert_last)
                    begin
                        cnt_next = '0;
                        ovf_next = 1'b0;
                        if (ovf_new)
                        begin
                            errc_next  = pnt_pkg::ST_MANY;
                            state_next = S_ERR;
                        end
                        else if (n_new < CNT_W'(3))
                        begin
                            errc_next  = pnt_pkg::ST_FEW;
                            state_next = S_ERR;
                        end
                        else
                        begin
                            n_next      = n_new;
                            term_next   = '0;
                            rcnt_next   = '0;
                            cmd.acc_clr = 1'b1;
                            state_next  = S_RD;
                        end
                    end
                    else
                    begin
                        cnt_next = n_new;
                        ovf_next = ovf_new;
                    end
                end
            end
            S_RD:
            begin
                cmd.rd_en = 1'b1;
                if (n_reg == CNT_W'(3))
                begin
                    unique case (rcnt_reg)
                        2'd1:    rd_addr = IDX_W'(1);
                        2'd3:    rd_addr = IDX_W'(2);
                        default: rd_addr = '0;
                    endcase
                end
                else if (n_reg == CNT_W'(4))
                begin
                    unique case (rcnt_reg)
                        2'd1:    rd_addr = IDX_W'(2);
                        2'd2:    rd_addr = IDX_W'(1);
                        2'd3:    rd_addr = IDX_W'(3);
                        default: rd_addr = '0;
                    endcase
                end
                else
                begin
                    unique case (rcnt_reg)
                        2'd0:    rd_addr = term_reg;
                        2'd3:    rd_addr = i2;
                        default: rd_addr = i1;
                    endcase
                end
                rcnt_next = rcnt_reg + 2'd1;
                if (rcnt_reg == 2'd3)
                begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                cmd.diff_en = 1'b1;
                mcnt_next   = '0;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                mcnt_next  = mcnt_reg + 4'd1;
                if ((n_reg == CNT_W'(4) && mcnt_reg == 4'(pnt_pkg::MS_BZBZ))
                    || (n_reg != CNT_W'(4) && mcnt_reg == 4'(pnt_pkg::MS_AYBX)))
                begin
                    state_next = S_MWAIT;
                end
            end
            S_MWAIT:
            begin
                // last product lands in the accumulators here
                if (n_reg > CNT_W'(4) && (CNT_W'(term_reg) + CNT_W'(1) != n_reg))
                begin
                    term_next  = term_reg + IDX_W'(1);
                    rcnt_next  = '0;
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.norm_init = 1'b1;
                state_next    = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (sts.big)
                begin
                    cmd.shift_en = 1'b1;
                end
                else
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.sq_en  = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_en = 1'b1;
                comp_next  = '0;
                bit_next   = 4'd14;
                state_next = S_SA;
            end
            S_SA:
            begin
                cmd.srch_a = 1'b1;
                state_next = S_SB;
            end
            S_SB:
            begin
                cmd.srch_b = 1'b1;
                state_next = S_SA;
                if (bit_reg == 4'd0)
                begin
                    bit_next = 4'd14;
                    if (comp_reg == 2'd2)
                    begin
                        tri_next    = '0;
                        corner_next = '0;
                        rot_next    = (n_reg == CNT_W'(4)) && sts.quad_rot;
                        state_next  = S_EMRD;
                    end
                    else
                    begin
                        comp_next = comp_reg + 2'd1;
                    end
                end
                else
                begin
                    bit_next = bit_reg - 4'd1;
                end
            end
            S_EMRD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_slot = 2'd0;
                rd_addr     = eidx;
                state_next  = S_EMWR;
            end
            S_EMWR:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (corner_reg == 2'd2)
                    begin
                        corner_next = '0;
                        tri_next    = tri_reg + IDX_W'(1);
                    end
                    else
                    begin
                        corner_next = corner_reg + 2'd1;
                    end
                    state_next = emit_last ? S_LOAD : S_EMRD;
                end
            end
            S_ERR:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_err  = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            n_reg      <= '0;
            term_reg   <= '0;
            rcnt_reg   <= '0;
            mcnt_reg   <= '0;
            comp_reg   <= '0;
            bit_reg    <= '0;
            tri_reg    <= '0;
            corner_reg <= '0;
            rot_reg    <= 1'b0;
            errc_reg   <= pnt_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
            n_reg      <= n_next;
            term_reg   <= term_next;
            rcnt_reg   <= rcnt_next;
            mcnt_reg   <= mcnt_next;
            comp_reg   <= comp_next;
            bit_reg    <= bit_next;
            tri_reg    <= tri_next;
            corner_reg <= corner_next;
            rot_reg    <= rot_next;
            errc_reg   <= errc_next;
        end
    end

    `PNT_ASSERT(a_load_free, clk, rst_n, !cmd.out_load || sts.out_free, "item loaded into a busy output register")
    `PNT_ASSERT_NEXT(a_last_stall, clk, rst_n, accept && vert_last, vert_stall, "input taken after the last vertex of a face")
    `PNT_ASSERT(a_cnt_range, clk, rst_n, cnt_reg <= CNT_W'(MAX_VERTS), "vertex count beyond the store")
    `PNT_ASSERT(a_shift_big, clk, rst_n, !cmd.shift_en || sts.big, "normal scaled below range")

endmodule

// ===== src/pnt_dp.sv =====
`timescale 1ns / 1ps

module pnt_dp #(
    parameter int MAX_VERTS  = pnt_pkg::MAX_VERTS_DEF,
    parameter int COORD_BITS = pnt_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pnt_pkg::vert_item_t           vert,
    input  pnt_pkg::pnt_cmd_t             cmd,
    input  logic [$clog2(MAX_VERTS)-1:0]  wr_addr,
    input  logic [$clog2(MAX_VERTS)-1:0]  rd_addr,
    output pnt_pkg::pnt_sts_t             sts,
    output logic                          res_valid,
    input  logic                          res_stall,
    output pnt_pkg::res_item_t            res
);

    localparam int CW = COORD_BITS;
    localparam int D  = COORD_BITS + 1;
    localparam int PW = 2 * D + 64;

    logic [3*CW-1:0]             mem [MAX_VERTS];
    logic [3*CW-1:0]             vtx_reg [4];
    logic [pnt_pkg::FACE_W-1:0]  face_reg;
    logic signed [D-1:0]         a_reg [3];
    logic signed [D-1:0]         b_reg [3];
    logic [63:0]                 prod_reg;
    pnt_pkg::mul_sel_t           psel_reg;
    logic                        pval_reg;
    logic [63:0]                 nrm_reg [3];
    logic [63:0]                 la_reg, lb_reg;
    logic                        neg_reg [3];
    logic [63:0]                 mag_reg [3];
    logic [29:0]                 rsq_reg [3];
    logic [31:0]                 s_reg;
    logic [14:0]                 v_reg;
    logic [31:0]                 tt_reg;
    logic [15:0]                 q_reg [3];
    logic                        out_valid_reg;
    pnt_pkg::res_item_t          out_reg;

    logic signed [D-1:0]         op1, op2;
    logic signed [2*D-1:0]       prod;
    logic signed [PW-1:0]        prod_w;
    logic [14:0]                 cand;
    logic [15:0]                 tval;
    logic [63:0]                 lhs, lim;
    logic [14:0]                 vnew;

    function automatic logic [CW-1:0] to_coord(input logic [pnt_pkg::POS_W-1:0] f);
        logic [63:0] z;
        z = 64'(f);
        return z[CW-1:0];
    endfunction

    function automatic logic signed [D-1:0] coord(input logic [3*CW-1:0] v,
                                                  input int k);
        logic signed [CW-1:0] c;
        c = v[(2-k)*CW +: CW];
        return D'(c);
    endfunction

    function automatic logic [pnt_pkg::POS_W-1:0] pos_out(input logic [3*CW-1:0] v,
                                                          input int k);
        logic signed [CW-1:0] c;
        logic signed [63:0]   w;
        c = v[(2-k)*CW +: CW];
        w = 64'(c);
        return w[pnt_pkg::POS_W-1:0];
    endfunction

    // vertex store
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= {to_coord(vert.pos_x), to_coord(vert.pos_y), to_coord(vert.pos_z)};
        end
        if (cmd.rd_en)
        begin
            vtx_reg[cmd.rd_slot] <= mem[rd_addr];
        end
        if (cmd.face_latch)
        begin
            face_reg <= vert.face_id;
        end
    end

    // edges and products
    always_comb
    begin
        unique case (cmd.mul_sel)
            pnt_pkg::MS_AYBZ: begin op1 = a_reg[1]; op2 = b_reg[2]; end
            pnt_pkg::MS_AZBY: begin op1 = a_reg[2]; op2 = b_reg[1]; end
            pnt_pkg::MS_AZBX: begin op1 = a_reg[2]; op2 = b_reg[0]; end
            pnt_pkg::MS_AXBZ: begin op1 = a_reg[0]; op2 = b_reg[2]; end
            pnt_pkg::MS_AXBY: begin op1 = a_reg[0]; op2 = b_reg[1]; end
            pnt_pkg::MS_AYBX: begin op1 = a_reg[1]; op2 = b_reg[0]; end
            pnt_pkg::MS_AXAX: begin op1 = a_reg[0]; op2 = a_reg[0]; end
            pnt_pkg::MS_AYAY: begin op1 = a_reg[1]; op2 = a_reg[1]; end
            pnt_pkg::MS_AZAZ: begin op1 = a_reg[2]; op2 = a_reg[2]; end
            pnt_pkg::MS_BXBX: begin op1 = b_reg[0]; op2 = b_reg[0]; end
            pnt_pkg::MS_BYBY: begin op1 = b_reg[1]; op2 = b_reg[1]; end
            pnt_pkg::MS_BZBZ: begin op1 = b_reg[2]; op2 = b_reg[2]; end
            default:          begin op1 = '0;       op2 = '0;       end
        endcase
        prod   = op1 * op2;
        prod_w = PW'(prod);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.diff_en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a_reg[k] <= coord(vtx_reg[0], k) - coord(vtx_reg[1], k);
                b_reg[k] <= coord(vtx_reg[2], k) - coord(vtx_reg[3], k);
            end
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_w[63:0];
            psel_reg <= cmd.mul_sel;
        end
        // sums wrap at 64 bits
        if (cmd.acc_clr)
        begin
            for (int k = 0; k < 3; k++)
            begin
                nrm_reg[k] <= '0;
            end
            la_reg <= '0;
            lb_reg <= '0;
        end
        else if (pval_reg)
        begin
            unique case (psel_reg)
                pnt_pkg::MS_AYBZ: nrm_reg[0] <= nrm_reg[0] + prod_reg;
                pnt_pkg::MS_AZBY: nrm_reg[0] <= nrm_reg[0] - prod_reg;
                pnt_pkg::MS_AZBX: nrm_reg[1] <= nrm_reg[1] + prod_reg;
                pnt_pkg::MS_AXBZ: nrm_reg[1] <= nrm_reg[1] - prod_reg;
                pnt_pkg::MS_AXBY: nrm_reg[2] <= nrm_reg[2] + prod_reg;
                pnt_pkg::MS_AYBX: nrm_reg[2] <= nrm_reg[2] - prod_reg;
                pnt_pkg::MS_AXAX,
                pnt_pkg::MS_AYAY,
                pnt_pkg::MS_AZAZ: la_reg <= la_reg + prod_reg;
                default:          lb_reg <= lb_reg + prod_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pval_reg <= 1'b0;
        end
        else
        begin
            pval_reg <= cmd.mul_en;
        end
    end

    // scaling and rounded unit normal, each result bit found by a trial (srch_a) and a compare (srch_b)
    always_comb
    begin
        cand = v_reg | (15'd1 << cmd.bitpos);
        tval = {cand, 1'b0} - 16'd1;
        lhs  = 64'(tt_reg) * 64'(s_reg);
        lim  = 64'({rsq_reg[cmd.comp], 30'd0});
        vnew = ((s_reg != 32'd0) && (lhs <= lim)) ? cand : v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.norm_init)
        begin
            for (int k = 0; k < 3; k++)
            begin
                neg_reg[k] <= nrm_reg[k][63];
                mag_reg[k] <= nrm_reg[k][63] ? 64'd0 - nrm_reg[k] : nrm_reg[k];
            end
        end
        else if (cmd.shift_en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                mag_reg[k] <= mag_reg[k] >> 1;
            end
        end
        if (cmd.sq_en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                rsq_reg[k] <= 30'(mag_reg[k][14:0]) * 30'(mag_reg[k][14:0]);
            end
        end
        if (cmd.sum_en)
        begin
            s_reg <= 32'(rsq_reg[0]) + 32'(rsq_reg[1]) + 32'(rsq_reg[2]);
            v_reg <= '0;
        end
        if (cmd.srch_a)
        begin
            tt_reg <= 32'(tval) * 32'(tval);
        end
        if (cmd.srch_b)
        begin
            if (cmd.bitpos == 4'd0)
            begin
                q_reg[cmd.comp] <= neg_reg[cmd.comp] ? 16'd0 - 16'(vnew) : 16'(vnew);
                v_reg <= '0;
            end
            else
            begin
                v_reg <= vnew;
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.out_err)
            begin
                out_reg.out_x       <= '0;
                out_reg.out_y       <= '0;
                out_reg.out_z       <= '0;
                out_reg.norm_x      <= '0;
                out_reg.norm_y      <= '0;
                out_reg.norm_z      <= '0;
                out_reg.status      <= cmd.err_code;
                out_reg.last_of_run <= 1'b1;
            end
            else
            begin
                out_reg.out_x       <= pos_out(vtx_reg[0], 0);
                out_reg.out_y       <= pos_out(vtx_reg[0], 1);
                out_reg.out_z       <= pos_out(vtx_reg[0], 2);
                out_reg.norm_x      <= q_reg[0];
                out_reg.norm_y      <= q_reg[1];
                out_reg.norm_z      <= q_reg[2];
                out_reg.status      <= pnt_pkg::ST_OK;
                out_reg.last_of_run <= cmd.out_last;
            end
            out_reg.out_face_id <= face_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.big      = (|mag_reg[0][63:15]) || (|mag_reg[1][63:15]) || (|mag_reg[2][63:15]);
    assign sts.quad_rot = !(la_reg < lb_reg);
    assign sts.out_free = !out_valid_reg || !res_stall;
    assign res_valid    = out_valid_reg;
    assign res          = out_reg;

endmodule

// ===== src/polygon_normal_triangulator.sv =====
`timescale 1ns / 1ps
// polygon face normal and triangulation
// vert channel: one vertex item per accepted cycle while collecting, with the
// face id (taken from the first vertex) and a last-vertex flag
// res channel: triangle corner items with position, unit normal in Q1.14,
// face id, status and a flag on the last item of the face
// collecting runs at one vertex per cycle; after the last vertex the input
// stalls while one shared multiplier works out the normal: the cross products
// of edges or quad diagonals (once for a triangle or quad, once per vertex
// for n >= 5), then the scaling shifts, squares and their sum, and a bitwise
// search for the rounded unit normal (a trial and a compare per result bit)
// each result item then takes a store read and an output register load
// an error face (fewer than three vertices or overflow) gives one item
// a stalled receiver holds the output register and the emission waits;
// the next face is taken as soon as its last item sits in the register
// reset clears the controller and the output valid; the store needs no clear

module polygon_normal_triangulator #(
    parameter int MAX_VERTS  = pnt_pkg::MAX_VERTS_DEF,
    parameter int COORD_BITS = pnt_pkg::COORD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                vert_valid,
    output logic                vert_stall,
    input  pnt_pkg::vert_item_t vert,
    output logic                res_valid,
    input  logic                res_stall,
    output pnt_pkg::res_item_t  res
);

    localparam int IDX_W = $clog2(MAX_VERTS);

    pnt_pkg::pnt_cmd_t  cmd;
    pnt_pkg::pnt_sts_t  sts;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   rd_addr;

    pnt_ctrl #(
        .MAX_VERTS (MAX_VERTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .vert_valid (vert_valid),
        .vert_last  (vert.last_vertex),
        .vert_stall (vert_stall),
        .sts        (sts),
        .cmd        (cmd),
        .wr_addr    (wr_addr),
        .rd_addr    (rd_addr)
    );

    pnt_dp #(
        .MAX_VERTS  (MAX_VERTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .vert      (vert),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .rd_addr   (rd_addr),
        .sts       (sts),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
